/* sv/dsr_pkg.sv */
// Shared types, constants and helper functions of the dekatron step/set/read controller.
package dsr_pkg;

  // Number of cathodes on the tube
  localparam int CATHODES = 10;

  // Configuration reset values
  localparam logic [15:0] PULSE_RESET  = 16'd250;
  localparam logic [15:0] SETTLE_RESET = 16'd250;
  localparam logic [7:0]  ATTEMPT_RESET = 8'd100;

  // Reciprocal for the miss-count modulo (exact for 8-bit operands)
  localparam int RECIP = (2**16 + CATHODES - 1) / CATHODES;

  // Configuration register indexes
  localparam logic [1:0] CFG_PULSE    = 2'd0;
  localparam logic [1:0] CFG_SETTLE   = 2'd1;
  localparam logic [1:0] CFG_ATTEMPTS = 2'd2;

  // Commands; COUNTOUT is internal and steps out a digit
  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_FWD      = 3'd1,
    OP_BACK     = 3'd2,
    OP_RESET    = 3'd3,
    OP_SET      = 3'd4,
    OP_READ     = 3'd5,
    OP_DREAD    = 3'd6,
    CMD_COUNTOUT = 3'd7
  } cmd_e;

  // Sequencer phases
  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_G1     = 7'b0000010,
    PH_G2     = 7'b0000100,
    PH_G3     = 7'b0001000,
    PH_G4     = 7'b0010000,
    PH_SETTLE = 7'b0100000,
    PH_SAMPLE = 7'b1000000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    cmd_e        cmd;
    logic [15:0] timer;
    logic [7:0]  attempts;
    logic [3:0]  steps;
    logic [3:0]  digit;
    logic        wb;
  } state_t;

  typedef struct packed {
    logic [15:0] pulse;
    logic [15:0] settle;
    logic [7:0]  attempts;
  } cfg_t;

  typedef struct packed {
    logic       guide1;
    logic       guide2;
    logic       busy;
    logic       done;
    logic       failed;
    logic [3:0] value;
  } result_t;

  // Digit seen after a number of missed steps: CATHODES-1 - (m mod CATHODES)
  function automatic logic [3:0] digit_from_misses(logic [7:0] m);
    logic [24:0] prod;
    logic [7:0]  quo;
    logic [7:0]  rem;
    prod = 25'(m) * 25'(RECIP);
    quo  = prod[23:16];
    rem  = m - 8'(16'(quo) * 16'(CATHODES));
    return 4'(CATHODES - 1) - rem[3:0];
  endfunction

endpackage

/* sv/dsr_step.sv */
// Next-state and result logic for one tick of the stepper sequencer.
module dsr_step
  import dsr_pkg::*;
(
  input  state_t     state_i,
  input  cfg_t       cfg_i,
  input  logic [2:0] op_i,
  input  logic [3:0] target_value_i,
  input  logic       cathode_zero_i,
  output state_t     state_o,
  output result_t    result_o
);

  always_comb begin
    state_t      n;
    logic [15:0] pt;
    logic [7:0]  limit;
    logic [7:0]  att_inc;
    logic        do_begin;
    logic        do_finish;
    logic        fin_fail;
    logic        fin_show;
    logic        first;
    logic        second;

    n         = state_i;
    do_begin  = 1'b0;
    do_finish = 1'b0;
    fin_fail  = 1'b0;
    fin_show  = 1'b0;
    pt        = (cfg_i.pulse == 16'd0) ? 16'd1 : cfg_i.pulse;
    limit     = (cfg_i.attempts == 8'd0) ? 8'd1 : cfg_i.attempts;
    att_inc   = state_i.attempts + 8'd1;

    unique case (state_i.phase)
      PH_IDLE: begin
        // take a new command
        if (op_i != OP_NONE && op_i != CMD_COUNTOUT) begin
          n.cmd      = cmd_e'(op_i);
          n.attempts = 8'd0;
          n.wb       = 1'b0;
          n.steps    = (target_value_i > 4'(CATHODES - 1)) ? 4'(CATHODES - 1)
                                                           : target_value_i;
          do_begin   = 1'b1;
        end
      end
      PH_G1, PH_G2, PH_G3, PH_G4: begin
        if (state_i.timer >= pt) begin
          if (state_i.phase == PH_G4) begin
            // step complete
            if (state_i.cmd == OP_FWD || state_i.cmd == OP_BACK) begin
              do_finish = 1'b1;
            end else if (state_i.cmd == CMD_COUNTOUT) begin
              n.steps = state_i.steps - 4'd1;
              if (n.steps == 4'd0) begin
                do_finish = 1'b1;
                fin_show  = state_i.wb;
              end else begin
                do_begin = 1'b1;
              end
            end else begin
              n.timer = 16'd1;
              n.phase = (cfg_i.settle == 16'd0) ? PH_SAMPLE : PH_SETTLE;
            end
          end else begin
            n.phase = phase_e'({state_i.phase[5:0], 1'b0});
            n.timer = 16'd1;
          end
        end else begin
          n.timer = state_i.timer + 16'd1;
        end
      end
      PH_SETTLE: begin
        if (state_i.timer >= cfg_i.settle) begin
          n.phase = PH_SAMPLE;
          n.timer = 16'd1;
        end else begin
          n.timer = state_i.timer + 16'd1;
        end
      end
      PH_SAMPLE: begin
        if (cathode_zero_i) begin
          if (state_i.cmd == OP_RESET) begin
            do_finish = 1'b1;
          end else if (state_i.cmd == OP_SET) begin
            // count out the target digit from zero
            if (state_i.steps == 4'd0) begin
              do_finish = 1'b1;
              fin_show  = state_i.wb;
            end else begin
              n.cmd    = CMD_COUNTOUT;
              do_begin = 1'b1;
            end
          end else if (state_i.cmd == OP_DREAD) begin
            n.digit   = digit_from_misses(state_i.attempts);
            do_finish = 1'b1;
            fin_show  = 1'b1;
          end else if (!state_i.wb) begin
            // read found zero: restore the digit next
            n.digit    = digit_from_misses(state_i.attempts);
            n.wb       = 1'b1;
            n.attempts = 8'd0;
            do_begin   = 1'b1;
          end else begin
            n.steps = state_i.digit;
            if (n.steps == 4'd0) begin
              do_finish = 1'b1;
              fin_show  = state_i.wb;
            end else begin
              n.cmd    = CMD_COUNTOUT;
              do_begin = 1'b1;
            end
          end
        end else begin
          n.attempts = att_inc;
          if (att_inc >= limit) begin
            do_finish = 1'b1;
            fin_fail  = 1'b1;
          end else begin
            do_begin = 1'b1;
          end
        end
      end
      default: begin
        n.phase = PH_IDLE;
        n.timer = 16'd0;
      end
    endcase

    if (do_begin) begin
      n.phase = PH_G1;
      n.timer = 16'd1;
    end

    result_o.done   = do_finish;
    result_o.failed = do_finish & fin_fail;
    result_o.value  = (do_finish && fin_show) ? n.digit : 4'd0;
    if (do_finish) begin
      n.phase = PH_IDLE;
      n.timer = 16'd0;
      n.wb    = 1'b0;
    end

    // guide drive from the updated phase; backward swaps the guides
    first  = (n.phase == PH_G1) || (n.phase == PH_G2);
    second = (n.phase == PH_G2) || (n.phase == PH_G3);
    if (n.cmd == OP_BACK) begin
      result_o.guide1 = second;
      result_o.guide2 = first;
    end else begin
      result_o.guide1 = first;
      result_o.guide2 = second;
    end
    result_o.busy = (n.phase != PH_IDLE);

    state_o = n;
  end

endmodule

/* sv/dsr_out_reg.sv */
// Result register that decouples the output channel from the tick input.
module dsr_out_reg
  import dsr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t data_q;

  // room for a new item when empty or when the held one leaves now
  assign space_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

/* sv/dekatron_step_set_read_controller.sv */
// Top level of the dekatron step/set/read controller.
//
// Input channel: one item per timer tick, carrying the command (op_i), the
// digit for a set command and the cathode-zero sense sample of that tick.
// Output channel: one result item per accepted tick with the guide drive
// levels, busy, a done pulse, the failed flag and the digit of a read.
// Configuration: cfg_we_i writes pulse ticks (index 0), settle ticks
// (index 1) or the attempt limit (index 2); other indexes are ignored.
// Output: the result of a tick is registered and offered in the cycle after it is accepted.
// Throughput: one tick per cycle while results are taken; the sequencer state
// and the result register both update in the accepting cycle.
// Reset: the sequencer goes idle, the registers return to 250 / 250 / 100,
// and the result register empties.
// Stall: while the receiver holds out_ready_i low with a result waiting,
// in_ready_o is low and the sequencer state holds; ticks are not lost.
module dekatron_step_set_read_controller
  import dsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [3:0]  target_value_i,
  input  logic        cathode_zero_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        guide1_o,
  output logic        guide2_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        failed_o,
  output logic [3:0]  read_value_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  result_t step_res;
  result_t out_res;
  logic    accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse    <= PULSE_RESET;
      cfg_q.settle   <= SETTLE_RESET;
      cfg_q.attempts <= ATTEMPT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PULSE:    cfg_q.pulse    <= cfg_data_i;
        CFG_SETTLE:   cfg_q.settle   <= cfg_data_i;
        CFG_ATTEMPTS: cfg_q.attempts <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  dsr_step u_step (
    .state_i        (state_q),
    .cfg_i          (cfg_q),
    .op_i           (op_i),
    .target_value_i (target_value_i),
    .cathode_zero_i (cathode_zero_i),
    .state_o        (state_d),
    .result_o       (step_res)
  );

  assign accept = in_valid_i && in_ready_o;

  // sequencer state advances once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase    <= PH_IDLE;
      state_q.cmd      <= OP_NONE;
      state_q.timer    <= 16'd0;
      state_q.attempts <= 8'd0;
      state_q.steps    <= 4'd0;
      state_q.digit    <= 4'd0;
      state_q.wb       <= 1'b0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  dsr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (step_res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign guide1_o     = out_res.guide1;
  assign guide2_o     = out_res.guide2;
  assign busy_res_o   = out_res.busy;
  assign done_res_o   = out_res.done;
  assign failed_o     = out_res.failed;
  assign read_value_o = out_res.value;

`ifndef ASSERT_OFF
  // a failure or a read digit is only reported on the finishing tick
  a_fail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (failed_o || read_value_o != 4'd0)) |-> done_res_o)
    else $error("failed or read value without done");

  // a finished command leaves the block idle with the guides released
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (!busy_res_o && !guide1_o && !guide2_o))
    else $error("done while busy or guides driven");

  // the phase timer is cleared whenever the sequencer is idle
  a_idle_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_IDLE) |-> (state_q.timer == 16'd0))
    else $error("idle with running phase timer");

  // sequencer state only moves on an accepted tick
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(state_q))
    else $error("state changed without an accepted item");
`endif

endmodule

/* tb/sv/dekatron_step_set_read_controller_tb.sv */
// Self-checking randomized testbench for the dekatron step/set/read controller.
module dekatron_step_set_read_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dsr_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped index, writes are dropped
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  // One timer tick as offered on the input channel
  typedef struct packed {
    logic [2:0] code;
    logic [3:0] tgt;
    logic       hit;
  } tick_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = OP_NONE;
  logic [3:0]  target = '0;
  logic        sense = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        guide1;
  logic        guide2;
  logic        busy;
  logic        done;
  logic        failed;
  logic [3:0]  read_value;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_PULSE;
  logic [15:0] cfg_data = '0;

  dekatron_step_set_read_controller u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (op),
    .target_value_i (target),
    .cathode_zero_i (sense),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .guide1_o       (guide1),
    .guide2_o       (guide2),
    .busy_res_o     (busy),
    .done_res_o     (done),
    .failed_o       (failed),
    .read_value_o   (read_value),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Sequencer prediction: registers and state as seen by the block
  // ---------------------------------------------------------------------
  logic [15:0] cfg_pulse = PULSE_RESET;
  logic [15:0] cfg_settle = SETTLE_RESET;
  logic [7:0]  cfg_tries = ATTEMPT_RESET;

  phase_e      seq_phase = PH_IDLE;
  cmd_e        cur_cmd = OP_NONE;
  logic [15:0] phase_timer = '0;
  logic [7:0]  miss_count = '0;
  logic [3:0]  steps_left = '0;
  logic [3:0]  digit = '0;
  logic        wb_pending = 1'b0;

  logic        tick_done;
  logic        tick_failed;
  logic [3:0]  tick_value;

  function automatic void start_step();
    seq_phase = PH_G1;
    phase_timer = 16'd1;
  endfunction

  function automatic void end_command(logic fail, logic show);
    seq_phase = PH_IDLE;
    phase_timer = '0;
    tick_done = 1'b1;
    tick_failed = fail;
    tick_value = show ? digit : 4'd0;
    wb_pending = 1'b0;
  endfunction

  // Step out steps_left positions, or finish at once when there are none
  function automatic void begin_countout();
    if (steps_left == 4'd0) begin
      end_command(1'b0, wb_pending);
    end else begin
      cur_cmd = CMD_COUNTOUT;
      start_step();
    end
  endfunction

  // Glow position implied by the number of missed steps before cathode zero
  function automatic logic [3:0] misses_to_digit(logic [7:0] misses);
    return 4'(CATHODES - 1 - (int'(misses) % CATHODES));
  endfunction

  // Advance the sequencer by one tick and return the result item it shows
  function automatic result_t dekatron_tick(tick_t t);
    logic [16:0] pulse_eff;
    logic [7:0]  limit;
    logic        first;
    logic        second;
    result_t     r;
    pulse_eff = (cfg_pulse == 16'd0) ? 17'd1 : {1'b0, cfg_pulse};
    limit = (cfg_tries == 8'd0) ? 8'd1 : cfg_tries;
    tick_done = 1'b0;
    tick_failed = 1'b0;
    tick_value = 4'd0;

    case (seq_phase)
      PH_IDLE: begin
        if (t.code != OP_NONE && t.code != CMD_COUNTOUT) begin
          cur_cmd = cmd_e'(t.code);
          miss_count = '0;
          wb_pending = 1'b0;
          steps_left = (t.tgt > 4'(CATHODES - 1)) ? 4'(CATHODES - 1) : t.tgt;
          start_step();
        end
      end
      PH_G1, PH_G2, PH_G3, PH_G4: begin
        if ({1'b0, phase_timer} >= pulse_eff) begin
          phase_timer = 16'd1;
          case (seq_phase)
            PH_G1: seq_phase = PH_G2;
            PH_G2: seq_phase = PH_G3;
            PH_G3: seq_phase = PH_G4;
            default: begin
              // full step done: plain steps end, count-out continues, searches settle
              if (cur_cmd == OP_FWD || cur_cmd == OP_BACK) begin
                end_command(1'b0, 1'b0);
              end else if (cur_cmd == CMD_COUNTOUT) begin
                steps_left = steps_left - 4'd1;
                if (steps_left == 4'd0) end_command(1'b0, wb_pending);
                else start_step();
              end else begin
                seq_phase = (cfg_settle == 16'd0) ? PH_SAMPLE : PH_SETTLE;
              end
            end
          endcase
        end else begin
          phase_timer = phase_timer + 16'd1;
        end
      end
      PH_SETTLE: begin
        if (phase_timer >= cfg_settle) begin
          seq_phase = PH_SAMPLE;
          phase_timer = 16'd1;
        end else begin
          phase_timer = phase_timer + 16'd1;
        end
      end
      PH_SAMPLE: begin
        if (t.hit) begin
          case (cur_cmd)
            OP_RESET: end_command(1'b0, 1'b0);
            OP_SET:   begin_countout();
            OP_DREAD: begin
              digit = misses_to_digit(miss_count);
              end_command(1'b0, 1'b1);
            end
            default: begin
              // read: first hit captures the digit, second hit restores it
              if (!wb_pending) begin
                digit = misses_to_digit(miss_count);
                wb_pending = 1'b1;
                miss_count = '0;
                start_step();
              end else begin
                steps_left = digit;
                begin_countout();
              end
            end
          endcase
        end else begin
          miss_count = miss_count + 8'd1;
          if (miss_count >= limit) end_command(1'b1, 1'b0);
          else start_step();
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        phase_timer = '0;
      end
    endcase

    // guide drive: forward g1, g1+g2, g2; back swaps the electrodes
    first = (seq_phase == PH_G1 || seq_phase == PH_G2);
    second = (seq_phase == PH_G2 || seq_phase == PH_G3);
    r.guide1 = (cur_cmd == OP_BACK) ? second : first;
    r.guide2 = (cur_cmd == OP_BACK) ? first : second;
    r.busy = (seq_phase != PH_IDLE);
    r.done = tick_done;
    r.failed = tick_failed;
    r.value = tick_value;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------
  tick_t   tick_queue[$];
  result_t expected_results[$];

  int miss_goal = 0;
  int wb_goal = 0;
  int ticks_made = 0;
  int commands_run = 0;
  int commands_failed = 0;
  int deepest_miss = 0;
  int settings_used = 1;
  logic [CATHODES-1:0] digits_seen = '0;

  int send_gap_pct = 13;
  int recv_stall_pct = 60;

  // Queue one tick and its predicted result
  task automatic push_tick(logic [2:0] op_v, logic [3:0] tgt_v, logic hit_v);
    tick_t   t;
    result_t r;
    logic    wb_was;
    t = '{code: op_v, tgt: tgt_v, hit: hit_v};
    wb_was = wb_pending;
    if (seq_phase == PH_SAMPLE && hit_v && int'(miss_count) > deepest_miss)
      deepest_miss = int'(miss_count);
    r = dekatron_tick(t);
    // write-back search of a read gets its own miss plan
    if (!wb_was && wb_pending) miss_goal = wb_goal;
    if (r.done) begin
      commands_run++;
      if (r.failed) commands_failed++;
      else if (cur_cmd == OP_DREAD || wb_was) digits_seen[r.value] = 1'b1;
    end
    tick_queue.push_back(t);
    expected_results.push_back(r);
    ticks_made++;
  endtask

  // Sense sample: follows the miss plan on sample ticks, with a little noise
  function automatic logic pick_sense();
    if (seq_phase != PH_SAMPLE) return 1'($urandom_range(0, 1));
    return (int'(miss_count) >= miss_goal) ^ ($urandom_range(0, 99) < 3);
  endfunction

  // Misses before the sense hits: mostly short, sometimes anywhere, sometimes never
  function automatic int draw_goal();
    int lim;
    int pick;
    lim = (cfg_tries == 8'd0) ? 1 : int'(cfg_tries);
    pick = $urandom_range(0, 99);
    if (pick < 65) return $urandom_range(0, (lim > 12) ? 12 : lim - 1);
    if (pick < 85) return $urandom_range(0, lim - 1);
    return lim;
  endfunction

  // Issue one command tick, then random ticks until the sequencer is idle again
  task automatic run_command(logic [2:0] op_v, logic [3:0] tgt_v, int goal, int goal_wb);
    miss_goal = goal;
    wb_goal = goal_wb;
    push_tick(op_v, tgt_v, 1'($urandom_range(0, 1)));
    while (seq_phase != PH_IDLE)
      push_tick(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), pick_sense());
  endtask

  task automatic random_ticks(int n);
    int         stop_at;
    int         pick;
    logic [2:0] op_v;
    stop_at = ticks_made + n;
    while (ticks_made < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) op_v = OP_NONE;
      else if (pick < 15) op_v = CMD_COUNTOUT;
      else op_v = 3'($urandom_range(OP_FWD, OP_DREAD));
      run_command(op_v, 4'($urandom_range(0, 15)), draw_goal(), draw_goal());
    end
  endtask

  // Hold off until every queued tick has produced its result
  task automatic drain();
    while (tick_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PULSE:    cfg_pulse = value;
      CFG_SETTLE:   cfg_settle = value;
      CFG_ATTEMPTS: cfg_tries = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] pulse_v, logic [15:0] settle_v,
                                logic [7:0] tries_v, int gap_pct, int stall_pct);
    drain();
    write_reg(CFG_PULSE, pulse_v);
    write_reg(CFG_SETTLE, settle_v);
    write_reg(CFG_ATTEMPTS, {8'($urandom), tries_v});
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------
  int send_calm = 0;

  always @(posedge clk) begin : drive_ticks
    tick_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // occasional stretches without gaps
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(0, 99) < 2) send_calm = $urandom_range(20, 80);
      if (tick_queue.size() != 0 &&
          (send_calm > 0 || $urandom_range(0, 99) >= send_gap_pct)) begin
        t = tick_queue.pop_front();
        in_valid <= 1'b1;
        op <= t.code;
        target <= t.tgt;
        sense <= t.hit;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  int recv_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 99) < 2) recv_calm = $urandom_range(20, 80);
      out_ready <= (recv_calm > 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------
  int checked = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{guide1: guide1, guide2: guide2, busy: busy, done: done,
                failed: failed, value: read_value};
        checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result item: g1=%b g2=%b busy=%b done=%b failed=%b value=%0d",
                     got.guide1, got.guide2, got.busy, got.done, got.failed, got.value);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"result item %0d mismatch: expected g1=%b g2=%b busy=%b done=%b ",
                        "failed=%b value=%0d, got g1=%b g2=%b busy=%b done=%b failed=%b ",
                        "value=%0d"}, checked,
                       want.guide1, want.guide2, want.busy, want.done, want.failed, want.value,
                       got.guide1, got.guide2, got.busy, got.done, got.failed, got.value);
          end
        end
      end

      // nothing moving on either channel for too long means a hang
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("dekatron_step_set_read_controller verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : test_sequence
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // settle time and attempt limit at their reset values, short guide phases
    write_reg(CFG_PULSE, 16'd1);
    run_command(OP_RESET, 4'd0, 0, 0);

    // directed commands with short timing and a limit of three attempts
    apply_settings(16'd1, 16'd0, 8'd3, 13, 60);
    run_command(OP_NONE, 4'd0, 0, 0);
    run_command(CMD_COUNTOUT, 4'd15, 0, 0);
    run_command(OP_FWD, 4'd0, 0, 0);
    run_command(OP_BACK, 4'd15, 0, 0);
    run_command(OP_RESET, 4'd0, 0, 0);
    run_command(OP_RESET, 4'd0, 3, 0);       // never hits: limit reached
    run_command(OP_SET, 4'd0, 0, 0);
    run_command(OP_SET, 4'd15, 1, 0);        // target saturates to the top digit
    run_command(OP_SET, 4'd9, 3, 0);
    run_command(OP_READ, 4'd0, 2, 0);
    run_command(OP_READ, 4'd0, 1, 3);        // write-back search fails
    run_command(OP_READ, 4'd0, 0, 0);        // digit nine, long write-back
    run_command(OP_DREAD, 4'd0, 0, 0);
    run_command(OP_DREAD, 4'd0, 2, 0);

    // zero pulse and zero attempts, then moderate timing
    apply_settings(16'd0, 16'd1, 8'd0, 13, 60);
    random_ticks(60);
    apply_settings(16'd2, 16'd3, 8'd12, 13, 60);
    write_reg(CFG_SPARE, 16'hFFFF);
    random_ticks(120);

    // sender idles more than the receiver; long searches wrap the digit
    apply_settings(16'd1, 16'd0, 8'd30, 60, 13);
    random_ticks(150);
    apply_settings(16'd3, 16'd2, 8'd1, 60, 13);
    random_ticks(60);

    // no idling on either side
    apply_settings(16'd1, 16'd2, 8'd20, 0, 0);
    random_ticks(80);
    apply_settings(16'd30, 16'd0, 8'd1, 0, 0);
    run_command(OP_BACK, 4'd0, 0, 0);
    apply_settings(16'd1, 16'd60, 8'd2, 0, 0);
    run_command(OP_RESET, 4'd0, 0, 0);

    drain();
    $display("%0d ticks under %0d register settings, %0d results checked, %0d mismatched",
             ticks_made, settings_used, checked, mismatches);
    $display("%0d commands finished (%0d at the attempt limit), read digits %b, %0d misses max",
             commands_run, commands_failed, digits_seen, deepest_miss);
    if (mismatches == 0) begin
      $display("dekatron_step_set_read_controller verification clean");
    end else begin
      $display("dekatron_step_set_read_controller verification failed");
    end
    $finish;
  end

endmodule
